>>> src/atapio_pkg.sv
// Shared types and constants of the ATA PIO LBA28 transfer sequencer.
package atapio_pkg;

  localparam int SECTOR_W = 28;
  localparam int TOTAL_W  = 29;
  localparam int POLL_W   = 12;
  localparam int CHUNK_W  = 9;
  localparam int WORDS_W  = 17;

  // Largest chunk issued with one command, and the log2 of the 16-bit words in a sector.
  localparam int MAX_CHUNK_SECTORS = 256;
  localparam int WORDS_SHIFT       = 8;

  // Request codes on the input channel.
  localparam logic [1:0] REQ_START  = 2'd0;
  localparam logic [1:0] REQ_IRQ    = 2'd1;
  localparam logic [1:0] REQ_STATUS = 2'd2;

  // Result kinds on the output channel.
  localparam logic [2:0] KIND_REG_WRITE = 3'd0;
  localparam logic [2:0] KIND_MOVE      = 3'd1;
  localparam logic [2:0] KIND_FINISHED  = 3'd2;
  localparam logic [2:0] KIND_REJECTED  = 3'd3;
  localparam logic [2:0] KIND_FAILURE   = 3'd4;

  // Command block register offsets.
  localparam logic [2:0] REG_COUNT      = 3'd2;
  localparam logic [2:0] REG_LBA_LO     = 3'd3;
  localparam logic [2:0] REG_LBA_MID    = 3'd4;
  localparam logic [2:0] REG_LBA_HI     = 3'd5;
  localparam logic [2:0] REG_DRIVE_HEAD = 3'd6;
  localparam logic [2:0] REG_COMMAND    = 3'd7;

  // Device and command bytes, status bits.
  localparam logic [7:0] DEV_FIXED = 8'hA0;
  localparam logic [7:0] DEV_LBA   = 8'h40;
  localparam logic [7:0] DEV_SLAVE = 8'h10;
  localparam logic [7:0] CMD_RD    = 8'h20;
  localparam logic [7:0] CMD_WR    = 8'h30;
  localparam int         ST_BSY_BIT = 7;
  localparam int         ST_DRQ_BIT = 3;

  typedef struct packed {
    logic                drive_select;
    logic [SECTOR_W-1:0] max_sector;
    logic [POLL_W-1:0]   poll_limit;
  } cfg_t;

  // First result of a run, if any.
  typedef enum logic [2:0] {
    HEAD_NONE,
    HEAD_DEVSEL,
    HEAD_REJECT,
    HEAD_FAIL,
    HEAD_MOVE
  } head_t;

  // Closing part of a run, if any.
  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_FINISH,
    TAIL_ISSUE
  } tail_t;

  // Compact description of all results caused by one input transfer.
  typedef struct packed {
    head_t               head;
    tail_t               tail;
    logic [SECTOR_W-1:0] head_sector;
    logic [CHUNK_W-1:0]  move_chunk;
    logic [SECTOR_W-1:0] issue_sector;
    logic [CHUNK_W-1:0]  issue_chunk;
    logic                writing;
    logic                slave;
  } run_t;

endpackage

>>> src/ata_pio_transfer_sequencer_unit.sv
// Top level of the ATA PIO LBA28 transfer sequencer with its APB register file.
// The first result of a request passes through the run queue, the back end's descriptor
// register and its output register. Throughput: one request transfer per cycle while the
// run queue has room; results leave at one per cycle while out_ready is high, a request
// causes up to 7 results, and runs follow each other without a gap.
// Reset is synchronous: control state clears and the registers return to their defaults.
module ata_pio_transfer_sequencer_unit import atapio_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  // APB register port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // Request channel.
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          req_type,
  input  logic [SECTOR_W-1:0] start_sector,
  input  logic [TOTAL_W-1:0]  sector_total,
  input  logic                is_write,
  input  logic [7:0]          status_byte,
  // Result channel.
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          result_kind,
  output logic [2:0]          reg_offset,
  output logic [7:0]          reg_value,
  output logic [WORDS_W-1:0]  word_count,
  output logic [SECTOR_W-1:0] chunk_sector,
  output logic                last_of_run
);

  // Register indexes; each register sits at byte address four times its index.
  localparam logic [1:0] IDX_DRIVE_SELECT = 2'd0;
  localparam logic [1:0] IDX_MAX_SECTOR   = 2'd1;
  localparam logic [1:0] IDX_POLL_LIMIT   = 2'd2;

  localparam logic [SECTOR_W-1:0] MAX_SECTOR_RESET = SECTOR_W'(163839);
  localparam logic [POLL_W-1:0]   POLL_LIMIT_RESET = POLL_W'(3000);

  logic                drive_select;
  logic [SECTOR_W-1:0] max_sector;
  logic [POLL_W-1:0]   poll_limit;
  logic                cfg_write;
  cfg_t                cfg;

  run_t run;
  logic run_push;
  logic q_full;
  logic q_valid;
  run_t q_data;
  logic q_pop;

  // The register file never stalls the bus. A write lands in the access phase.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_select <= 1'b0;
      max_sector   <= MAX_SECTOR_RESET;
      poll_limit   <= POLL_LIMIT_RESET;
    end else if (cfg_write) begin
      case (paddr[3:2])
        IDX_DRIVE_SELECT: drive_select <= pwdata[0];
        IDX_MAX_SECTOR:   max_sector   <= pwdata[SECTOR_W-1:0];
        IDX_POLL_LIMIT:   poll_limit   <= pwdata[POLL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      IDX_DRIVE_SELECT: prdata = {31'd0, drive_select};
      IDX_MAX_SECTOR:   prdata = 32'(max_sector);
      IDX_POLL_LIMIT:   prdata = 32'(poll_limit);
      default:          prdata = '0;
    endcase
  end

  assign cfg.drive_select = drive_select;
  assign cfg.max_sector   = max_sector;
  assign cfg.poll_limit   = poll_limit;

  // The front end decides, in the cycle of the transfer, every result that a request
  // causes and hands a compact run descriptor to the queue. It only stalls when the
  // queue is full, so slow result consumers never block state tracking until then.
  atapio_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .start_sector (start_sector),
    .sector_total (sector_total),
    .is_write     (is_write),
    .status_byte  (status_byte),
    .cfg          (cfg),
    .queue_full   (q_full),
    .run          (run),
    .run_push     (run_push)
  );

  atapio_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (run_push),
    .push_data (run),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .data      (q_data)
  );

  // The back end walks each descriptor: an optional leading result (drive select,
  // rejection, failure or data move), then, if present, the finished report or the six
  // register writes that issue the next chunk. Results sit in an output register.
  atapio_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .reg_offset   (reg_offset),
    .reg_value    (reg_value),
    .word_count   (word_count),
    .chunk_sector (chunk_sector),
    .last_of_run  (last_of_run)
  );

`ifndef ASSERT_OFF
  // A descriptor is never offered to a full queue, or it would be dropped.
  assert property (@(posedge clk) disable iff (rst)
    run_push |-> !q_full)
    else $error("run descriptor pushed into a full queue");
`endif

endmodule

>>> src/atapio_front.sv
// Front end: accepts requests, keeps the transfer state and emits run descriptors.
module atapio_front import atapio_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          req_type,
  input  logic [SECTOR_W-1:0] start_sector,
  input  logic [TOTAL_W-1:0]  sector_total,
  input  logic                is_write,
  input  logic [7:0]          status_byte,
  input  cfg_t                cfg,
  input  logic                queue_full,
  output run_t                run,
  output logic                run_push
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT_IRQ,
    PH_POLL,
    PH_WAIT_DONE
  } phase_t;

  phase_t              phase, phase_next;
  logic [SECTOR_W-1:0] next_sector, next_sector_next;
  logic [TOTAL_W-1:0]  sectors_left, sectors_left_next;
  logic [CHUNK_W-1:0]  chunk_size, chunk_size_next;
  logic                writing, writing_next;
  logic                awaiting_irq, awaiting_irq_next;
  logic [POLL_W-1:0]   polls_used, polls_used_next;

  logic                accept;
  logic [SECTOR_W-1:0] fin_sector;
  logic [TOTAL_W-1:0]  fin_left;
  logic [SECTOR_W-1:0] src_sector;
  logic [TOTAL_W-1:0]  src_left;
  logic                src_wr;
  logic [CHUNK_W-1:0]  issue_chunk;
  logic [POLL_W-1:0]   polls_inc;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  assign fin_sector = next_sector + SECTOR_W'(chunk_size);
  assign fin_left   = (sectors_left >= TOTAL_W'(chunk_size)) ?
                      sectors_left - TOTAL_W'(chunk_size) : '0;

  // A start issues from the request itself, every other step from the finished chunk.
  assign src_sector  = (req_type == REQ_START) ? start_sector : fin_sector;
  assign src_left    = (req_type == REQ_START) ? sector_total : fin_left;
  assign src_wr      = (req_type == REQ_START) ? is_write : writing;
  assign issue_chunk = (src_left > TOTAL_W'(MAX_CHUNK_SECTORS)) ?
                       CHUNK_W'(MAX_CHUNK_SECTORS) : src_left[CHUNK_W-1:0];
  assign polls_inc   = polls_used + POLL_W'(1);

  always_comb begin
    phase_next        = phase;
    next_sector_next  = next_sector;
    sectors_left_next = sectors_left;
    chunk_size_next   = chunk_size;
    writing_next      = writing;
    awaiting_irq_next = awaiting_irq;
    polls_used_next   = polls_used;

    run.head         = HEAD_NONE;
    run.tail         = TAIL_NONE;
    run.head_sector  = next_sector;
    run.move_chunk   = chunk_size;
    run.issue_sector = src_sector;
    run.issue_chunk  = issue_chunk;
    run.writing      = src_wr;
    run.slave        = cfg.drive_select;

    case (req_type)
      REQ_START: begin
        if (phase == PH_IDLE) begin
          if (start_sector > cfg.max_sector) begin
            run.head        = HEAD_REJECT;
            run.head_sector = start_sector;
          end else begin
            next_sector_next  = start_sector;
            sectors_left_next = sector_total;
            writing_next      = is_write;
            chunk_size_next   = '0;
            run.head          = HEAD_DEVSEL;
            run.head_sector   = start_sector;
            if (sector_total == '0) begin
              run.tail = TAIL_FINISH;
            end else begin
              run.tail          = TAIL_ISSUE;
              chunk_size_next   = issue_chunk;
              awaiting_irq_next = 1'b1;
              polls_used_next   = '0;
              phase_next        = is_write ? PH_POLL : PH_WAIT_IRQ;
            end
          end
        end
      end
      REQ_IRQ: begin
        if (awaiting_irq) begin
          awaiting_irq_next = 1'b0;
          if (phase == PH_WAIT_IRQ) begin
            phase_next      = PH_POLL;
            polls_used_next = '0;
          end else if (phase == PH_WAIT_DONE) begin
            next_sector_next  = fin_sector;
            sectors_left_next = fin_left;
            if (fin_left == '0) begin
              run.tail   = TAIL_FINISH;
              phase_next = PH_IDLE;
            end else begin
              run.tail          = TAIL_ISSUE;
              chunk_size_next   = issue_chunk;
              awaiting_irq_next = 1'b1;
              polls_used_next   = '0;
              phase_next        = writing ? PH_POLL : PH_WAIT_IRQ;
            end
          end
        end
      end
      REQ_STATUS: begin
        if (phase == PH_POLL) begin
          if (status_byte[ST_BSY_BIT]) begin
            polls_used_next = polls_inc;
            // A wrapped counter also counts as an exhausted budget.
            if (polls_inc >= cfg.poll_limit || polls_inc == '0) begin
              run.head   = HEAD_FAIL;
              phase_next = PH_IDLE;
            end
          end else if (status_byte[ST_DRQ_BIT]) begin
            run.head = HEAD_MOVE;
            if (!writing || !awaiting_irq) begin
              next_sector_next  = fin_sector;
              sectors_left_next = fin_left;
              if (fin_left == '0) begin
                run.tail   = TAIL_FINISH;
                phase_next = PH_IDLE;
              end else begin
                run.tail          = TAIL_ISSUE;
                chunk_size_next   = issue_chunk;
                awaiting_irq_next = 1'b1;
                polls_used_next   = '0;
                phase_next        = writing ? PH_POLL : PH_WAIT_IRQ;
              end
            end else begin
              phase_next = PH_WAIT_DONE;
            end
          end else begin
            run.head   = HEAD_FAIL;
            phase_next = PH_IDLE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign run_push = accept && (run.head != HEAD_NONE || run.tail != TAIL_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      next_sector  <= '0;
      sectors_left <= '0;
      chunk_size   <= '0;
      writing      <= 1'b0;
      awaiting_irq <= 1'b0;
      polls_used   <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      next_sector  <= next_sector_next;
      sectors_left <= sectors_left_next;
      chunk_size   <= chunk_size_next;
      writing      <= writing_next;
      awaiting_irq <= awaiting_irq_next;
      polls_used   <= polls_used_next;
    end
  end

`ifndef ASSERT_OFF
  // An interrupt is only armed by issuing a command, which leaves idle.
  assert property (@(posedge clk) disable iff (rst)
    $rose(awaiting_irq) |-> (phase == PH_POLL || phase == PH_WAIT_IRQ))
    else $error("interrupt armed while the sequencer is idle");
`endif

endmodule

>>> src/atapio_queue.sv
// Short queue of run descriptors between the front end and the back end.
module atapio_queue import atapio_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  run_t push_data,
  output logic full,
  input  logic pop,
  output logic valid,
  output run_t data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  run_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign valid   = (count != '0);
  assign data    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> src/atapio_back.sv
// Back end: expands each run descriptor into result transfers, one per cycle while out_ready is high.
module atapio_back import atapio_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  run_t                q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          result_kind,
  output logic [2:0]          reg_offset,
  output logic [7:0]          reg_value,
  output logic [WORDS_W-1:0]  word_count,
  output logic [SECTOR_W-1:0] chunk_sector,
  output logic                last_of_run
);

  run_t       cur;
  logic       busy;
  logic [2:0] step;

  logic                has_head;
  logic [2:0]          n_results;
  logic [2:0]          tail_idx;
  logic                last;
  logic                adv;
  logic                load;
  logic [7:0]          dev_byte;
  logic [2:0]          res_kind;
  logic [2:0]          res_offset;
  logic [7:0]          res_value;
  logic [WORDS_W-1:0]  res_words;
  logic [SECTOR_W-1:0] res_sector;

  assign has_head  = (cur.head != HEAD_NONE);
  assign n_results = {2'b00, has_head} +
                     ((cur.tail == TAIL_ISSUE) ? 3'd6 :
                      (cur.tail == TAIL_FINISH) ? 3'd1 : 3'd0);
  assign tail_idx  = step - {2'b00, has_head};
  assign last      = (step == n_results - 3'd1);
  assign dev_byte  = DEV_FIXED | DEV_LBA | (cur.slave ? DEV_SLAVE : 8'h00);

  // The output register is free when empty or being drained this cycle.
  assign adv   = !out_valid || out_ready;
  assign load  = q_valid && (!busy || (adv && last));
  assign q_pop = load;

  always_comb begin
    res_kind   = KIND_FINISHED;
    res_offset = '0;
    res_value  = '0;
    res_words  = '0;
    res_sector = '0;
    if (has_head && step == 3'd0) begin
      res_sector = cur.head_sector;
      case (cur.head)
        HEAD_DEVSEL: begin
          res_kind   = KIND_REG_WRITE;
          res_offset = REG_DRIVE_HEAD;
          res_value  = dev_byte;
        end
        HEAD_REJECT: res_kind = KIND_REJECTED;
        HEAD_FAIL:   res_kind = KIND_FAILURE;
        HEAD_MOVE: begin
          res_kind  = KIND_MOVE;
          res_words = WORDS_W'(cur.move_chunk) << WORDS_SHIFT;
        end
        default: res_sector = '0;
      endcase
    end else if (cur.tail == TAIL_ISSUE) begin
      res_kind   = KIND_REG_WRITE;
      res_sector = cur.issue_sector;
      case (tail_idx)
        3'd0: begin
          res_offset = REG_COUNT;
          res_value  = cur.issue_chunk[7:0];
        end
        3'd1: begin
          res_offset = REG_LBA_LO;
          res_value  = cur.issue_sector[7:0];
        end
        3'd2: begin
          res_offset = REG_LBA_MID;
          res_value  = cur.issue_sector[15:8];
        end
        3'd3: begin
          res_offset = REG_LBA_HI;
          res_value  = cur.issue_sector[23:16];
        end
        3'd4: begin
          res_offset = REG_DRIVE_HEAD;
          res_value  = dev_byte | {4'b0000, cur.issue_sector[27:24]};
        end
        default: begin
          res_offset = REG_COMMAND;
          res_value  = cur.writing ? CMD_WR : CMD_RD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_data;
    end
    if (adv && busy) begin
      result_kind  <= res_kind;
      reg_offset   <= res_offset;
      reg_value    <= res_value;
      word_count   <= res_words;
      chunk_sector <= res_sector;
      last_of_run  <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= busy;
      end
      if (load) begin
        busy <= 1'b1;
        step <= '0;
      end else if (adv && busy) begin
        if (last) begin
          busy <= 1'b0;
        end else begin
          step <= step + 3'd1;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  // Finished, rejected and failed always close a run.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == KIND_FINISHED || result_kind == KIND_REJECTED ||
                  result_kind == KIND_FAILURE) |-> last_of_run)
    else $error("terminal result not marked last");

  // The command byte ends every chunk issue.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_REG_WRITE && reg_offset == REG_COMMAND
      |-> last_of_run)
    else $error("command write not last of run");
`endif

endmodule
